// ----- src/efc_pkg.sv -----
// ----------------------------------------------------------------------------
// efc_pkg: shared types and constants for the Ethernet frame classifier
// Frame kinds, header constants and the frame record passed front to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package efc_pkg;

    // frame kinds as reported on o_frame_kind
    localparam logic [2:0] KIND_DIX   = 3'd0;
    localparam logic [2:0] KIND_IPV4  = 3'd1;
    localparam logic [2:0] KIND_ARP   = 3'd2;
    localparam logic [2:0] KIND_RAW   = 3'd3;
    localparam logic [2:0] KIND_SNAP  = 3'd4;
    localparam logic [2:0] KIND_LLC   = 3'd5;
    localparam int         NUM_KINDS  = 6;

    // header constants
    localparam logic [15:0] MAX_DIX_LEN = 16'h05DC;
    localparam logic [15:0] TYPE_IPV4   = 16'h0800;
    localparam logic [15:0] TYPE_ARP    = 16'h0806;
    localparam logic [15:0] LLC_RAW     = 16'hFFFF;
    localparam logic [15:0] LLC_SNAP    = 16'hAAAA;
    localparam logic [16:0] ARP_SIZE    = 17'd42;
    localparam logic [16:0] HDR_SIZE    = 17'd14;

    // byte at which each kind is decided
    localparam logic [16:0] DECIDE_DIX  = 17'd13;
    localparam logic [16:0] DECIDE_LLC  = 17'd15;
    localparam logic [16:0] DECIDE_IPV4 = 17'd17;

    // records waiting between parser and counter stage
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic [47:0] arp_sender_mac;
        logic [47:0] arp_target_mac;
        logic [16:0] frame_size;
    } t_frame_rec;

endpackage

// ----- src/efc_front.sv -----
// ----------------------------------------------------------------------------
// efc_front: byte parser
// Tracks the frame offset, captures header fields and emits one frame
// record on the frame's last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module efc_front
    import efc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    output logic       o_rec_push,
    output t_frame_rec o_rec
);

    logic [16:0] r_offset, n_offset;
    logic [16:0] r_size,   n_size;
    logic [15:0] r_type,   n_type;
    logic [15:0] r_llc,    n_llc;
    logic [47:0] r_dst,    n_dst;
    logic [47:0] r_src,    n_src;
    logic [47:0] r_asm,    n_asm;
    logic [47:0] r_atm,    n_atm;
    logic [31:0] r_sip,    n_sip;
    logic [31:0] r_tip,    n_tip;

    logic        w_ipv4;
    logic        w_arp;
    logic [16:0] w_decide;
    logic        w_last;
    logic [2:0]  w_kind;

    always_comb begin
        n_size = r_size;
        n_type = r_type;
        n_llc  = r_llc;
        n_dst  = r_dst;
        n_src  = r_src;
        n_asm  = r_asm;
        n_atm  = r_atm;
        n_sip  = r_sip;
        n_tip  = r_tip;

        w_ipv4 = (r_offset >= 17'd14) && (r_type == TYPE_IPV4);
        w_arp  = (r_offset >= 17'd14) && (r_type == TYPE_ARP);

        // Ethernet header
        if (r_offset < 17'd6) begin
            n_dst = {r_dst[39:0], i_data_byte};
        end else if (r_offset < 17'd12) begin
            n_src = {r_src[39:0], i_data_byte};
        end else if (r_offset < 17'd14) begin
            n_type = {r_type[7:0], i_data_byte};
            if (r_offset == 17'd13) begin
                n_size = (n_type == TYPE_ARP) ? ARP_SIZE : ({1'b0, n_type} + HDR_SIZE);
            end
        end else if (r_offset < 17'd16) begin
            n_llc = {r_llc[7:0], i_data_byte};
        end

        // payload fields, by type
        if (w_ipv4) begin
            if (r_offset == 17'd16) begin
                n_size = {1'b0, i_data_byte, 8'h00};
            end else if (r_offset == 17'd17) begin
                n_size = (r_size | {9'h000, i_data_byte}) + HDR_SIZE;
            end else if (r_offset >= 17'd26 && r_offset < 17'd30) begin
                n_sip = {r_sip[23:0], i_data_byte};
            end else if (r_offset >= 17'd30 && r_offset < 17'd34) begin
                n_tip = {r_tip[23:0], i_data_byte};
            end
        end else if (w_arp) begin
            if (r_offset >= 17'd22 && r_offset < 17'd28) begin
                n_asm = {r_asm[39:0], i_data_byte};
            end else if (r_offset >= 17'd28 && r_offset < 17'd32) begin
                n_sip = {r_sip[23:0], i_data_byte};
            end else if (r_offset >= 17'd32 && r_offset < 17'd38) begin
                n_atm = {r_atm[39:0], i_data_byte};
            end else if (r_offset >= 17'd38 && r_offset < 17'd42) begin
                n_tip = {r_tip[23:0], i_data_byte};
            end
        end

        if (n_type > MAX_DIX_LEN) begin
            w_decide = (n_type == TYPE_IPV4) ? DECIDE_IPV4 : DECIDE_DIX;
            if (n_type == TYPE_IPV4) begin
                w_kind = KIND_IPV4;
            end else if (n_type == TYPE_ARP) begin
                w_kind = KIND_ARP;
            end else begin
                w_kind = KIND_DIX;
            end
        end else begin
            w_decide = DECIDE_LLC;
            if (n_llc == LLC_RAW) begin
                w_kind = KIND_RAW;
            end else if (n_llc == LLC_SNAP) begin
                w_kind = KIND_SNAP;
            end else begin
                w_kind = KIND_LLC;
            end
        end

        // deciding byte reached and declared size covered
        w_last   = (r_offset >= w_decide) &&
                   (({1'b0, r_offset} + 18'd1) >= {1'b0, n_size});
        n_offset = r_offset + 17'd1;
    end

    assign o_rec_push = i_accept && w_last;

    always_comb begin
        o_rec.kind           = w_kind;
        o_rec.dst_mac        = n_dst;
        o_rec.src_mac        = n_src;
        o_rec.sender_ip      = n_sip;
        o_rec.target_ip      = n_tip;
        o_rec.arp_sender_mac = n_asm;
        o_rec.arp_target_mac = n_atm;
        o_rec.frame_size     = n_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && w_last)) begin
            r_offset <= '0;
            r_size   <= '0;
            r_type   <= '0;
            r_llc    <= '0;
            r_dst    <= '0;
            r_src    <= '0;
            r_asm    <= '0;
            r_atm    <= '0;
            r_sip    <= '0;
            r_tip    <= '0;
        end else if (i_accept) begin
            r_offset <= n_offset;
            r_size   <= n_size;
            r_type   <= n_type;
            r_llc    <= n_llc;
            r_dst    <= n_dst;
            r_src    <= n_src;
            r_asm    <= n_asm;
            r_atm    <= n_atm;
            r_sip    <= n_sip;
            r_tip    <= n_tip;
        end
    end

endmodule

// ----- src/efc_queue.sv -----
// ----------------------------------------------------------------------------
// efc_queue: short record queue
// Register-based FIFO of frame records between parser and counter stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module efc_queue
    import efc_pkg::*;
#(
    parameter int DEPTH = 4
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_rec i_rec,
    input  logic       i_pop,
    output t_frame_rec o_rec,
    output logic       o_empty,
    output logic       o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_frame_rec      r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- src/efc_back.sv -----
// ----------------------------------------------------------------------------
// efc_back: frame and kind counters with result register
// Counts each record, tags it with running counts and holds it for pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module efc_back
    import efc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_frame_rec  i_rec,
    output logic        o_q_pop,
    input  logic        i_pop,
    output logic        o_valid,
    output t_frame_rec  o_rec,
    output logic [31:0] o_frame_number,
    output logic [31:0] o_kind_count
);

    logic [COUNT_WIDTH-1:0] r_frame_cnt;
    logic [COUNT_WIDTH-1:0] r_kind_cnt [NUM_KINDS];
    logic [COUNT_WIDTH-1:0] w_kind_sel;
    logic [COUNT_WIDTH-1:0] n_frame_cnt;
    logic [COUNT_WIDTH-1:0] n_kind_cnt;
    logic [63:0]            w_frame_ext;
    logic [63:0]            w_kind_ext;

    logic                   r_valid;
    t_frame_rec             r_rec;
    logic [31:0]            r_frame_number;
    logic [31:0]            r_kind_count;

    assign o_q_pop = !i_q_empty && (!r_valid || i_pop);

    always_comb begin
        w_kind_sel = '0;
        for (int k = 0; k < NUM_KINDS; k++) begin
            if (i_rec.kind == 3'(k)) begin
                w_kind_sel = r_kind_cnt[k];
            end
        end
        n_frame_cnt = (&r_frame_cnt) ? r_frame_cnt : r_frame_cnt + 1'b1;
        n_kind_cnt  = (&w_kind_sel)  ? w_kind_sel  : w_kind_sel + 1'b1;
        w_frame_ext = 64'(n_frame_cnt);
        w_kind_ext  = 64'(n_kind_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cnt <= '0;
            for (int k = 0; k < NUM_KINDS; k++) begin
                r_kind_cnt[k] <= '0;
            end
        end else if (o_q_pop) begin
            r_frame_cnt <= n_frame_cnt;
            for (int k = 0; k < NUM_KINDS; k++) begin
                if (i_rec.kind == 3'(k)) begin
                    r_kind_cnt[k] <= n_kind_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rec          <= i_rec;
            r_frame_number <= w_frame_ext[31:0];
            r_kind_count   <= w_kind_ext[31:0];
        end
    end

    assign o_valid        = r_valid;
    assign o_rec          = r_rec;
    assign o_frame_number = r_frame_number;
    assign o_kind_count   = r_kind_count;

endmodule

// ----- src/ethernet_frame_classifier.sv -----
// ----------------------------------------------------------------------------
// ethernet_frame_classifier: per-frame type classification of a byte stream
// Throughput: one byte per cycle while full is low; the parser never waits on a frame's content.
// A frame's record passes from the parser through the record queue and then the
// counter/result register, after which its result is poppable.
// full rises only when the 4-entry record queue between parser and counters
// holds 4 records. Reset (synchronous, active low) clears offset and counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ethernet_frame_classifier
    import efc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input, queue-like
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    // result output, queue-like
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_frame_kind,
    output logic [47:0] o_dst_mac,
    output logic [47:0] o_src_mac,
    output logic [31:0] o_sender_ip,
    output logic [31:0] o_target_ip,
    output logic [47:0] o_arp_sender_mac,
    output logic [47:0] o_arp_target_mac,
    output logic [16:0] o_frame_size,
    output logic [31:0] o_frame_number,
    output logic [31:0] o_kind_count
);

    // Front: header parser. Runs one byte per accepted word and pushes a
    // complete frame record on the frame's last byte.
    logic       w_accept;
    logic       w_rec_push;
    t_frame_rec w_front_rec;

    // Queue between parser and counter stage.
    t_frame_rec w_q_rec;
    logic       w_q_empty;
    logic       w_q_full;
    logic       w_q_pop;

    // Back: counters and the result register.
    logic       w_out_valid;
    t_frame_rec w_out_rec;

    // Input stalls only while the record queue is full. This is slightly
    // conservative (mid-frame bytes could go on), but keeps the path short.
    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    efc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_data_byte),
        .o_rec_push  (w_rec_push),
        .o_rec       (w_front_rec)
    );

    efc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rec_push),
        .i_rec   (w_front_rec),
        .i_pop   (w_q_pop),
        .o_rec   (w_q_rec),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    // The counter stage takes a record whenever its result register is free
    // or is being emptied in the same cycle.
    efc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (w_q_empty),
        .i_rec          (w_q_rec),
        .o_q_pop        (w_q_pop),
        .i_pop          (pop),
        .o_valid        (w_out_valid),
        .o_rec          (w_out_rec),
        .o_frame_number (o_frame_number),
        .o_kind_count   (o_kind_count)
    );

    assign empty            = !w_out_valid;
    assign o_frame_kind     = w_out_rec.kind;
    assign o_dst_mac        = w_out_rec.dst_mac;
    assign o_src_mac        = w_out_rec.src_mac;
    assign o_sender_ip      = w_out_rec.sender_ip;
    assign o_target_ip      = w_out_rec.target_ip;
    assign o_arp_sender_mac = w_out_rec.arp_sender_mac;
    assign o_arp_target_mac = w_out_rec.arp_target_mac;
    assign o_frame_size     = w_out_rec.frame_size;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------

    // The parser never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rec_push |-> !w_q_full)
        else $error("record pushed into full queue");

    // Every frame is at least one header long.
    a_min_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_frame_size >= HDR_SIZE))
        else $error("frame size below header size");

    // ARP hardware addresses are captured for ARP frames only.
    a_arp_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_frame_kind != KIND_ARP)) |->
            ((o_arp_sender_mac == '0) && (o_arp_target_mac == '0)))
        else $error("ARP address on non-ARP frame");

    // A result always carries a nonzero frame and kind count while COUNT_WIDTH is at most 32.
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_frame_number != '0) && (o_kind_count != '0)))
        else $error("zero running count on result");

endmodule
